>>> design/clcd_pkg.sv
// Shared types, codes and pin-state tables for the character LCD nibble-bus sequencer.
`timescale 1ns / 1ps

package clcd_pkg;

   // Request kinds
   localparam logic [1:0] KIND_INIT   = 2'd0;
   localparam logic [1:0] KIND_CMD    = 2'd1;
   localparam logic [1:0] KIND_DATA   = 2'd2;
   localparam logic [1:0] KIND_CURSOR = 2'd3;

   // Cursor addressing
   localparam logic [7:0] ROW_TOP      = 8'd0;
   localparam logic [7:0] ROW_BOTTOM   = 8'd1;
   localparam logic [7:0] DDRAM_SET    = 8'h80;
   localparam logic [7:0] ROW1_OFFSET  = 8'h40;

   // Init command bytes
   localparam logic [7:0] CMD_HOME     = 8'h02;
   localparam logic [7:0] CMD_FUNC_SET = 8'h28;
   localparam logic [7:0] CMD_DISP_ON  = 8'h0e;
   localparam logic [7:0] CMD_CLEAR    = 8'h01;
   localparam logic [7:0] CMD_ENTRY    = 8'h06;

   // Hold times in microseconds
   localparam logic [14:0] HOLD_PULSE      = 15'd1;
   localparam logic [14:0] HOLD_PULSE_DATA = 15'd2;
   localparam logic [14:0] HOLD_SETUP      = 15'd200;
   localparam logic [14:0] HOLD_LAST       = 15'd2000;
   localparam logic [14:0] HOLD_POWER_UP   = 15'd20000;
   localparam logic [14:0] HOLD_LONG_CMD   = 15'd12000;
   localparam logic [14:0] HOLD_SHORT_CMD  = 15'd3000;
   localparam logic [14:0] HOLD_MID_CMD    = 15'd4000;

   // Step counts: init is one wait state plus five bytes, a byte is four states
   localparam logic [4:0] INIT_LAST_STEP = 5'd20;
   localparam logic [4:0] BYTE_LAST_STEP = 5'd3;
   localparam logic [2:0] INIT_LAST_CMD  = 3'd4;

   // Byte phases
   localparam logic [1:0] PH_HI_EN  = 2'd0;
   localparam logic [1:0] PH_HI_LOW = 2'd1;
   localparam logic [1:0] PH_LO_EN  = 2'd2;
   localparam logic [1:0] PH_LO_LOW = 2'd3;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] value;
      logic [7:0] row;
      logic [7:0] col;
   } req_type;

   typedef struct packed {
      logic        reg_select;
      logic        enable;
      logic [3:0]  nibble;
      logic [14:0] hold_us;
      logic        last;
   } rsp_type;

   // One classified job as it sits in the queue
   typedef struct packed {
      logic       is_init;
      logic       rs;
      logic [7:0] data;
   } job_type;

   function automatic logic [7:0] init_cmd(input logic [2:0] idx);
      logic [7:0] c;
      unique case (idx)
         3'd0:    c = CMD_HOME;
         3'd1:    c = CMD_FUNC_SET;
         3'd2:    c = CMD_DISP_ON;
         3'd3:    c = CMD_CLEAR;
         default: c = CMD_ENTRY;
      endcase
      return c;
   endfunction

   // Last-state hold of each init command, in microseconds
   function automatic logic [14:0] init_hold(input logic [2:0] idx);
      logic [14:0] h;
      unique case (idx)
         3'd0:    h = HOLD_LONG_CMD;
         3'd1:    h = HOLD_SHORT_CMD;
         3'd2:    h = HOLD_MID_CMD;
         3'd3:    h = HOLD_LONG_CMD;
         default: h = HOLD_SHORT_CMD;
      endcase
      return h;
   endfunction

   // Pin state for a given step of a job
   function automatic rsp_type lcd_state(input job_type job, input logic [4:0] step);
      logic [4:0]  seq;
      logic [2:0]  idx;
      logic [1:0]  phase;
      logic [7:0]  data_b;
      logic [14:0] final_hold;
      logic        is_last;
      rsp_type     r;
      seq = step - 5'd1;
      if (job.is_init) begin
         idx        = seq[4:2];
         phase      = seq[1:0];
         data_b     = init_cmd(idx);
         final_hold = init_hold(idx);
         is_last    = (idx == INIT_LAST_CMD);
      end else begin
         idx        = 3'd0;
         phase      = step[1:0];
         data_b     = job.data;
         final_hold = HOLD_LAST;
         is_last    = 1'b1;
      end
      r.reg_select = job.rs;
      r.last       = 1'b0;
      unique case (phase)
         PH_HI_EN: begin
            r.enable  = 1'b1;
            r.nibble  = data_b[7:4];
            r.hold_us = HOLD_PULSE;
         end
         PH_HI_LOW: begin
            r.enable  = 1'b0;
            r.nibble  = data_b[7:4];
            r.hold_us = HOLD_SETUP;
         end
         PH_LO_EN: begin
            r.enable  = 1'b1;
            r.nibble  = data_b[3:0];
            r.hold_us = job.rs ? HOLD_PULSE_DATA : HOLD_PULSE;
         end
         default: begin
            r.enable  = 1'b0;
            r.nibble  = data_b[3:0];
            r.hold_us = final_hold;
            r.last    = is_last;
         end
      endcase
      // Power-up wait opens the init sequence
      if (job.is_init && (step == 5'd0)) begin
         r.reg_select = 1'b0;
         r.enable     = 1'b0;
         r.nibble     = 4'd0;
         r.hold_us    = HOLD_POWER_UP;
         r.last       = 1'b0;
      end
      return r;
   endfunction

endpackage

>>> design/char_lcd_nibble_bus_sequencer.sv
// Top level of the character LCD nibble-bus sequencer.
//
//   channel  dir  handshake        payload
//   req      in   req_valid/stall  kind, value, row, col
//   rsp      out  rsp_valid/stall  reg_select, enable, nibble, hold_us, last
//
// One pin state leaves per cycle while rsp_stall is low; a cursor move to a row
// other than 0 or 1 yields no pin state and is dropped at entry.
// The sequencer's output register sets that rate.
// Requests are taken every cycle while the job queue (QUEUE_DEPTH entries) has room.
// Synchronous reset empties the queue and the output register.
`timescale 1ns / 1ps

module char_lcd_nibble_bus_sequencer #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  clcd_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output clcd_pkg::rsp_type rsp_data
);

   logic              keep;
   logic              full;
   logic              push;
   logic              pop;
   logic              head_valid;
   clcd_pkg::job_type new_job;
   clcd_pkg::job_type head_job;

   assign req_stall = full;
   assign push      = req_valid && !full && keep;

   clcd_front u_front (
      .req  (req_data),
      .keep (keep),
      .job  (new_job)
   );

   clcd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (new_job),
      .full       (full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   clcd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

>>> design/clcd_front.sv
// Request classifier: turns a request into a queue job or drops it.
`timescale 1ns / 1ps

module clcd_front (
   input  clcd_pkg::req_type req,
   output logic              keep,
   output clcd_pkg::job_type job
);

   logic [7:0] row1_col;

   assign row1_col = req.col + clcd_pkg::ROW1_OFFSET;

   // Classify by kind; cursor moves to row 0 or 1 become a command byte, others are dropped
   always_comb begin
      keep        = 1'b1;
      job.is_init = 1'b0;
      job.rs      = 1'b0;
      job.data    = req.value;
      unique case (req.kind)
         clcd_pkg::KIND_INIT: begin
            job.is_init = 1'b1;
         end
         clcd_pkg::KIND_CMD: begin
            job.rs = 1'b0;
         end
         clcd_pkg::KIND_DATA: begin
            job.rs = 1'b1;
         end
         default: begin
            if (req.row == clcd_pkg::ROW_TOP) begin
               job.data = clcd_pkg::DDRAM_SET | req.col;
            end else if (req.row == clcd_pkg::ROW_BOTTOM) begin
               job.data = clcd_pkg::DDRAM_SET | row1_col;
            end else begin
               keep = 1'b0;
            end
         end
      endcase
   end

endmodule

>>> design/clcd_queue.sv
// Short job queue between the classifier and the pin sequencer.
`timescale 1ns / 1ps

module clcd_queue #(
   parameter int DEPTH = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  clcd_pkg::job_type push_job,
   output logic              full,
   input  logic              pop,
   output logic              head_valid,
   output clcd_pkg::job_type head_job
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(DEPTH);

   clcd_pkg::job_type slots_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full       = (count_ff == CNT_MAX);
   assign head_valid = (count_ff != '0);
   assign head_job   = slots_ff[rd_ptr_ff];

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_MAX) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_MAX) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Job storage
   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

>>> design/clcd_back.sv
// Pin sequencer: steps through the states of the job at the queue head.
`timescale 1ns / 1ps

module clcd_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              head_valid,
   input  clcd_pkg::job_type head_job,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output clcd_pkg::rsp_type rsp_data
);

   logic              rsp_valid_ff, rsp_valid_in;
   clcd_pkg::rsp_type rsp_data_ff, rsp_data_in;
   logic [4:0]        step_ff, step_in;
   logic              advance;
   logic              at_final;

   assign advance  = !rsp_valid_ff || !rsp_stall;
   assign at_final = (step_ff == (head_job.is_init ? clcd_pkg::INIT_LAST_STEP
                                                   : clcd_pkg::BYTE_LAST_STEP));
   assign pop      = advance && head_valid && at_final;

   // Next pin state into the output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      step_in      = step_ff;
      if (advance) begin
         rsp_valid_in = head_valid;
         rsp_data_in  = clcd_pkg::lcd_state(head_job, step_ff);
         if (head_valid) begin
            step_in = at_final ? 5'd0 : step_ff + 5'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         step_ff      <= 5'd0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         step_ff      <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
